/* design/rmdp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmdp_pkg
// Shared types and constants for the RGB to mono dither packer.
// ----------------------------------------------------------------------------
package rmdp_pkg;

  typedef enum logic [0:0] {
    CFG_DITHER_ENABLE = 1'b0,
    CFG_THRESHOLD     = 1'b1
  } cfg_index_t;

  localparam logic       DITHER_ENABLE_RST = 1'b1;
  localparam logic [7:0] THRESHOLD_RST     = 8'd128;

endpackage

/* design/rgb_to_mono_dither_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_mono_dither_packer
// Converts RGB pixels to 1-bit mono with right-neighbor error diffusion and
// packs the bits MSB first into bytes, padding every row to an aligned size.
//
// Pixels enter on the in_ stream in scan order; in_tlast marks the last pixel
// of a row. Packed bytes leave on the out_ stream; out_tlast marks the final
// byte of a row, after any zero padding. The cfg_ channel writes the dither
// enable and threshold registers and is always ready; write it only while
// the block is idle.
// A pixel is taken every cycle while the output side keeps up and no row
// padding is pending. Luma is formed as the pixel is captured into the pixel
// register; error diffusion and bit packing then work from the pixel register
// and load the output register. A row end holds the pixel register while its
// zero padding bytes, up to ROW_ALIGN_BYTES - 1 of them, are sent.
// When the receiver stalls, the output register holds its byte; a pixel that
// completes no byte still passes, and the input stalls once a byte is waiting.
// Reset empties both registers, clears the carried error and the packing
// state, and sets dither enable to 1 and threshold to 128.
// ----------------------------------------------------------------------------
module rgb_to_mono_dither_packer
  import rmdp_pkg::*;
#(
  parameter int unsigned ROW_ALIGN_BYTES = 4,
  parameter int unsigned FRACTION_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        in_tlast,   // row_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // packed_byte [7:0]
  output logic        out_tlast,  // row_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned LW = FB + 9;
  localparam int unsigned CW = FB + 8;
  localparam int unsigned VW = FB + 10;
  localparam int unsigned EW = FB + 9;
  localparam int unsigned MW = FB + 12;
  localparam int unsigned PW = (ROW_ALIGN_BYTES > 1) ? $clog2(ROW_ALIGN_BYTES) : 1;

  localparam logic [LW-1:0] W_RED   = LW'(((64'd19595 << FB) + 64'd32768) >> 16);
  localparam logic [LW-1:0] W_GREEN = LW'(((64'd38470 << FB) + 64'd32768) >> 16);
  localparam logic [LW-1:0] W_BLUE  = LW'(((64'd7471 << FB) + 64'd32768) >> 16);
  localparam logic [CW-1:0] FULL_SCALE = {8'd255, {FB{1'b0}}};
  localparam logic [PW:0]   ALIGN      = (PW + 1)'(ROW_ALIGN_BYTES);

  logic                 dither_en_r;
  logic [7:0]           threshold_r;
  logic                 pix_valid_r;
  logic [LW-1:0]        luma_r;
  logic                 row_end_r;
  logic signed [CW-1:0] carry_r;
  logic [7:0]           acc_r;
  logic [2:0]           bit_pos_r;
  logic [PW-1:0]        phase_r;
  logic [PW-1:0]        pad_cnt_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;
  logic                 out_last_r;

  logic [LW-1:0]        luma_nxt;
  logic signed [VW-1:0] v_sum;
  logic [CW-1:0]        v_cl;
  logic [CW-1:0]        thr_fix;
  logic                 pix_bit;
  logic signed [EW-1:0] err;
  logic signed [MW-1:0] err7;
  logic signed [MW-1:0] err_sh;
  logic signed [CW-1:0] carry_nxt;
  logic [7:0]           acc_with_bit;
  logic                 byte_full;
  logic                 pix_emits;
  logic                 out_free;
  logic                 pix_consume;
  logic                 pad_emit;
  logic                 emit;
  logic [7:0]           emit_data;
  logic                 emit_last;
  logic [PW:0]          phase_inc;
  logic [PW-1:0]        phase_nxt;
  logic [PW-1:0]        pads_nxt;
  logic                 in_accept;

  assign luma_nxt = W_RED * LW'(in_tdata[7:0]) + W_GREEN * LW'(in_tdata[15:8])
                  + W_BLUE * LW'(in_tdata[23:16]);

  assign thr_fix = {threshold_r, {FB{1'b0}}};

  always_comb begin
    v_sum = $signed({1'b0, luma_r}) + VW'(carry_r);
    if (v_sum < 0) begin
      v_cl = '0;
    end else if (v_sum > $signed({2'b00, FULL_SCALE})) begin
      v_cl = FULL_SCALE;
    end else begin
      v_cl = v_sum[CW-1:0];
    end
    if (dither_en_r) begin
      pix_bit = (v_cl > thr_fix);
    end else begin
      pix_bit = (luma_r > {1'b0, thr_fix});
    end
    err    = $signed({1'b0, v_cl}) - $signed({1'b0, (pix_bit ? FULL_SCALE : CW'(0))});
    err7   = (MW'(err) <<< 3) - MW'(err);
    err_sh = err7 >>> 4;
    if (dither_en_r && !row_end_r) begin
      carry_nxt = err_sh[CW-1:0];
    end else begin
      carry_nxt = '0;
    end
  end

  assign acc_with_bit = pix_bit ? (acc_r | (8'h80 >> bit_pos_r)) : acc_r;
  assign byte_full    = (bit_pos_r == 3'd7);
  assign pix_emits    = row_end_r || byte_full;
  assign out_free     = !out_valid_r || out_tready;
  assign pix_consume  = pix_valid_r && (pad_cnt_r == '0) && (!pix_emits || out_free);
  assign pad_emit     = (pad_cnt_r != '0) && out_free;
  assign emit         = pad_emit || (pix_consume && pix_emits);

  assign phase_inc = {1'b0, phase_r} + (PW + 1)'(1);
  assign phase_nxt = (phase_inc == ALIGN) ? '0 : phase_inc[PW-1:0];
  assign pads_nxt  = (phase_nxt == '0) ? '0 : PW'(ALIGN - {1'b0, phase_nxt});

  always_comb begin
    if (pad_emit) begin
      emit_data = '0;
      emit_last = (pad_cnt_r == PW'(1));
    end else begin
      emit_data = acc_with_bit;
      emit_last = row_end_r && (pads_nxt == '0);
    end
  end

  assign in_tready  = !pix_valid_r || pix_consume;
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_en_r <= DITHER_ENABLE_RST;
      threshold_r <= THRESHOLD_RST;
      pix_valid_r <= 1'b0;
      carry_r     <= '0;
      acc_r       <= '0;
      bit_pos_r   <= '0;
      phase_r     <= '0;
      pad_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_DITHER_ENABLE: dither_en_r <= cfg_data[0];
          CFG_THRESHOLD:     threshold_r <= cfg_data;
          default:           dither_en_r <= dither_en_r;
        endcase
      end
      if (in_accept) begin
        pix_valid_r <= 1'b1;
      end else if (pix_consume) begin
        pix_valid_r <= 1'b0;
      end
      if (pix_consume) begin
        carry_r <= carry_nxt;
        if (pix_emits) begin
          acc_r <= '0;
        end else begin
          acc_r <= acc_with_bit;
        end
        bit_pos_r <= row_end_r ? 3'd0 : bit_pos_r + 3'd1;
        if (row_end_r) begin
          pad_cnt_r <= pads_nxt;
        end
      end else if (pad_emit) begin
        pad_cnt_r <= pad_cnt_r - PW'(1);
      end
      if (emit) begin
        phase_r     <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      luma_r    <= luma_nxt;
      row_end_r <= in_tlast;
    end
    if (emit) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
    end
  end

  a_pad_blocks_pixel : assert property (@(posedge clk) disable iff (!rst_n)
    (pad_cnt_r != '0) |-> !pix_consume)
    else $error("pixel consumed while row padding is pending");

  a_row_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (pix_consume && row_end_r) |=> (carry_r == '0 && acc_r == '0 && bit_pos_r == '0))
    else $error("row end did not clear the packing state");

  a_plain_no_carry : assert property (@(posedge clk) disable iff (!rst_n)
    (pix_consume && !dither_en_r) |=> (carry_r == '0))
    else $error("carried error kept with dithering off");

  a_last_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (phase_r == '0))
    else $error("row last byte not on an aligned boundary");

endmodule
